>>> rtl/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/ucd_pkg.sv
// shared types and constants of the cross detector
package ucd_pkg;

    localparam int PIX_W      = 8;
    localparam int COORD_W    = 4;
    localparam int CROSS_W    = 4;
    localparam int GRID_W     = 5;
    localparam int ARM_W      = CROSS_W - 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = GRID_W;

    localparam logic [CROSS_W-1:0] CROSS_RST = 4'd3;
    localparam logic [GRID_W-1:0]  GRID_RST  = 5'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CROSS_SIZE = 1'b0,
        CFG_GRID_SIZE  = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic             hit;
        logic [PIX_W-1:0] label;
    } t_scan_res;

endpackage

>>> rtl/ucd_ram.sv
// generic simple dual port ram with registered read
module ucd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/ucd_scan.sv
// read sequencer that checks the centre and the four arms of one candidate
`include "assert_macros.svh"

module ucd_scan #(
    parameter int GRID_SIZE = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  logic [$clog2(GRID_SIZE)-1:0]            i_row,
    input  logic [$clog2(GRID_SIZE)-1:0]            i_col,
    input  logic [ucd_pkg::ARM_W-1:0]               i_arm,
    output logic                                    o_re,
    output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0]  o_raddr,
    input  logic [ucd_pkg::PIX_W-1:0]               i_rdata,
    output ucd_pkg::t_scan_res                      o_res
);
    import ucd_pkg::*;

    localparam int POS_W  = $clog2(GRID_SIZE);
    localparam int ADDR_W = $clog2(GRID_SIZE * GRID_SIZE);
    localparam int LEFT_W = ARM_W + 3;

    typedef enum logic [1:0] {
        DIR_DOWN,
        DIR_UP,
        DIR_RIGHT,
        DIR_LEFT
    } t_dir;

    logic              r_busy;
    logic [POS_W-1:0]  r_cr;
    logic [POS_W-1:0]  r_cc;
    logic [ARM_W-1:0]  r_arm;
    t_dir              r_dir;
    logic [ARM_W-1:0]  r_step;
    logic [LEFT_W-1:0] r_left;
    logic              r_dvld;
    logic              r_first;
    logic              r_fail;
    logic [PIX_W-1:0]  r_lab;

    logic [POS_W-1:0]  rd_row;
    logic [POS_W-1:0]  rd_col;
    logic              rd_en;

    assign rd_en = r_busy && (r_left != '0);

    always_comb begin
        rd_row = r_cr;
        rd_col = r_cc;
        case (r_dir)
            DIR_DOWN:  rd_row = r_cr + POS_W'(r_step);
            DIR_UP:    rd_row = r_cr - POS_W'(r_step);
            DIR_RIGHT: rd_col = r_cc + POS_W'(r_step);
            DIR_LEFT:  rd_col = r_cc - POS_W'(r_step);
            default: ;
        endcase
    end

    assign o_re    = rd_en;
    assign o_raddr = ADDR_W'(ADDR_W'(rd_row) * ADDR_W'(GRID_SIZE)) + ADDR_W'(rd_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_dvld <= 1'b0;
            r_left <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_cr    <= i_row;
            r_cc    <= i_col;
            r_arm   <= i_arm;
            r_dir   <= DIR_DOWN;
            r_step  <= '0;
            r_left  <= LEFT_W'({i_arm, 2'b00}) + LEFT_W'(1);
            r_dvld  <= 1'b0;
            r_first <= 1'b1;
            r_fail  <= 1'b0;
        end else if (r_busy) begin
            r_dvld <= rd_en;
            if (rd_en) begin
                r_left <= r_left - LEFT_W'(1);
                if (r_step == r_arm) begin
                    r_step <= ARM_W'(1);
                    r_dir  <= t_dir'(r_dir + 2'd1);
                end else begin
                    r_step <= r_step + ARM_W'(1);
                end
            end
            if (r_dvld) begin
                if (r_first) begin
                    r_first <= 1'b0;
                    r_lab   <= i_rdata;
                    if (i_rdata == '0) begin
                        r_fail <= 1'b1;
                    end
                end else if (i_rdata != r_lab) begin
                    r_fail <= 1'b1;
                end
            end
            if (!rd_en && !r_dvld) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_res.busy  = r_busy;
    assign o_res.done  = r_busy && (r_left == '0) && !r_dvld;
    assign o_res.hit   = !r_fail;
    assign o_res.label = r_lab;

    `ASSERT_IMPL(a_start_idle, i_start, !r_busy)
    `ASSERT_IMPL(a_data_in_scan, r_dvld, r_busy)
    `ASSERT_NEXT(a_done_ends, o_res.done && !i_start, !r_busy)

endmodule

>>> rtl/uniform_cross_detector.sv
// top level of the cross detector: config, raster position, frame store, result register
`include "assert_macros.svh"

// Cells arrive in raster order and are written into a frame store of GRID_SIZE x GRID_SIZE
// labels. An item that does not complete a candidate cross leaves o_stall low. An item
// that is the bottom arm end of a candidate centre starts a check that reads the centre and
// the 4*arm arm cells through the single read port of the frame store, one read per cycle,
// and o_stall stays high until the check ends; a found cross waits there too while the previous
// result has not been taken. The frame store holds no reset value: a grid size change in mid
// frame that makes a check read a cell never written gives an undefined result. Configuration
// writes are always taken (o_cfg_ready high).
module uniform_cross_detector #(
    parameter int GRID_SIZE = 16,
    parameter int MAX_ARM   = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [ucd_pkg::PIX_W-1:0]        i_pixel_value,
    input  logic                             i_start_of_frame,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [ucd_pkg::COORD_W-1:0]      o_center_row,
    output logic [ucd_pkg::COORD_W-1:0]      o_center_col,
    output logic [ucd_pkg::PIX_W-1:0]        o_cross_value,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ucd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ucd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ucd_pkg::*;

    localparam int POS_W  = $clog2(GRID_SIZE);
    localparam int CNT_W  = $clog2(GRID_SIZE + 1);
    localparam int CMP_W  = (CNT_W > GRID_W) ? CNT_W : GRID_W;
    localparam int SUM_W  = CMP_W + 1;
    localparam int ADDR_W = $clog2(GRID_SIZE * GRID_SIZE);
    localparam int DEPTH  = GRID_SIZE * GRID_SIZE;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HOLD
    } t_state;

    t_state             r_state;
    logic [CROSS_W-1:0] r_cross_size;
    logic [GRID_W-1:0]  r_grid_size;
    logic [POS_W-1:0]   r_row;
    logic [POS_W-1:0]   r_col;
    logic [POS_W-1:0]   r_cr;
    logic [POS_W-1:0]   r_cc;
    logic [PIX_W-1:0]   r_hold_lab;
    logic               r_out_vld;
    logic [COORD_W-1:0] r_out_row;
    logic [COORD_W-1:0] r_out_col;
    logic [PIX_W-1:0]   r_out_lab;

    logic [CNT_W-1:0]   g_eff;
    logic [ARM_W-1:0]   arm;
    logic [ARM_W-1:0]   arm_raw;
    logic [CNT_W-1:0]   pos_r;
    logic [CNT_W-1:0]   pos_c;
    logic [CNT_W-1:0]   n_row;
    logic [CNT_W-1:0]   n_col;
    logic               in_acc;
    logic               out_free;
    logic               hit_done;
    logic               out_load;
    logic               cand;
    logic [POS_W-1:0]   cand_row;
    logic               scan_start;

    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [PIX_W-1:0]   rd_data;
    logic [ADDR_W-1:0]  wr_addr;
    t_scan_res          scan_res;

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_valid && !o_stall;
    assign out_free    = !r_out_vld || !i_stall;
    assign hit_done    = (r_state == S_SCAN) && scan_res.done && scan_res.hit;
    assign out_load    = (hit_done || (r_state == S_HOLD)) && out_free;

    always_comb begin
        if (r_grid_size == '0) begin
            g_eff = CNT_W'(1);
        end else if (CMP_W'(r_grid_size) > CMP_W'(GRID_SIZE)) begin
            g_eff = CNT_W'(GRID_SIZE);
        end else begin
            g_eff = CNT_W'(r_grid_size);
        end
        arm_raw = r_cross_size[CROSS_W-1:1];
        arm     = (int'(arm_raw) > MAX_ARM) ? ARM_W'(MAX_ARM) : arm_raw;
    end

    // position of this cell, then of the next one
    always_comb begin
        if (i_start_of_frame) begin
            pos_r = '0;
            pos_c = '0;
        end else begin
            pos_r = CNT_W'(r_row);
            pos_c = CNT_W'(r_col);
            if (pos_c >= g_eff) begin
                pos_c = '0;
                pos_r = pos_r + CNT_W'(1);
            end
            if (pos_r >= g_eff) begin
                pos_r = '0;
            end
        end
        n_row = pos_r;
        n_col = pos_c + CNT_W'(1);
        if (n_col >= g_eff) begin
            n_col = '0;
            n_row = pos_r + CNT_W'(1);
            if (n_row >= g_eff) begin
                n_row = '0;
            end
        end
    end

    assign cand = (SUM_W'(pos_r) >= SUM_W'({arm, 1'b0}))
               && (SUM_W'(pos_c) >= SUM_W'(arm))
               && (SUM_W'(pos_c) + SUM_W'(arm) < SUM_W'(g_eff));
    assign cand_row   = POS_W'(SUM_W'(pos_r) - SUM_W'(arm));
    assign scan_start = in_acc && cand;
    assign wr_addr    = ADDR_W'(ADDR_W'(pos_r) * ADDR_W'(GRID_SIZE)) + ADDR_W'(pos_c);

    ucd_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (wr_addr),
        .i_wdata (i_pixel_value),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    ucd_scan #(
        .GRID_SIZE (GRID_SIZE)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (scan_start),
        .i_row   (cand_row),
        .i_col   (POS_W'(pos_c)),
        .i_arm   (arm),
        .o_re    (rd_en),
        .o_raddr (rd_addr),
        .i_rdata (rd_data),
        .o_res   (scan_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cross_size <= CROSS_RST;
            r_grid_size  <= GRID_RST;
            r_row        <= '0;
            r_col        <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_CROSS_SIZE: r_cross_size <= i_cfg_data[CROSS_W-1:0];
                    CFG_GRID_SIZE:  r_grid_size  <= i_cfg_data[GRID_W-1:0];
                    default: ;
                endcase
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_stall) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_row <= POS_W'(n_row);
                        r_col <= POS_W'(n_col);
                        if (cand) begin
                            r_cr    <= cand_row;
                            r_cc    <= POS_W'(pos_c);
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (scan_res.done) begin
                        if (!scan_res.hit) begin
                            r_state <= S_IDLE;
                        end else if (out_free) begin
                            r_out_row <= COORD_W'(r_cr);
                            r_out_col <= COORD_W'(r_cc);
                            r_out_lab <= scan_res.label;
                            r_state   <= S_IDLE;
                        end else begin
                            r_hold_lab <= scan_res.label;
                            r_state    <= S_HOLD;
                        end
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_out_row <= COORD_W'(r_cr);
                        r_out_col <= COORD_W'(r_cc);
                        r_out_lab <= r_hold_lab;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_out_vld;
    assign o_center_row  = r_out_row;
    assign o_center_col  = r_out_col;
    assign o_cross_value = r_out_lab;

    `ASSERT_IMPL(a_idle_scan_quiet, r_state == S_IDLE, !scan_res.busy)
    `ASSERT_IMPL(a_hold_full, r_state == S_HOLD, r_out_vld)
    `ASSERT_NEXT(a_hit_loads, hit_done && !r_out_vld, o_valid)

endmodule

>>> test/uniform_cross_detector_tb.sv
// self-checking testbench of the uniform cross detector with stalls on both sides
`timescale 1ns / 1ps

module uniform_cross_detector_tb;
    import ucd_pkg::*;

    localparam int STORE_SIDE    = 16;
    localparam int ARM_LIMIT     = 4;
    localparam int DRAIN_CYCLES  = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_TARGET = 500;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             sof;
    } t_cell_item;

    typedef struct packed {
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_write;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIX_W-1:0]   label;
    } t_cross_hit;

    typedef enum {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_TOGGLE} t_flow_mode;

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_valid          = 1'b0;
    logic [PIX_W-1:0]      i_pixel_value    = '0;
    logic                  i_start_of_frame = 1'b0;
    logic                  i_stall          = 1'b0;
    logic                  i_cfg_valid      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;
    logic                  o_stall;
    logic                  o_valid;
    logic [COORD_W-1:0]    o_center_row;
    logic [COORD_W-1:0]    o_center_col;
    logic [PIX_W-1:0]      o_cross_value;
    logic                  o_cfg_ready;

    t_cell_item pending_cells[$];
    t_cfg_write cfg_writes[$];
    t_cross_hit hits_due[$];
    t_cell_item next_cell;
    t_cfg_write next_write;
    t_cross_hit due_hit;

    // predictor state
    logic [PIX_W-1:0]   cell_store [STORE_SIDE*STORE_SIDE];
    int                 pos_row = 0;
    int                 pos_col = 0;
    logic [CROSS_W-1:0] span_cfg = CROSS_RST;
    logic [GRID_W-1:0]  grid_cfg = GRID_RST;

    // stimulus side view of position and written cells
    bit                 gen_written [STORE_SIDE*STORE_SIDE];
    int                 gen_row = 0;
    int                 gen_col = 0;
    logic [CROSS_W-1:0] gen_cross = CROSS_RST;
    logic [GRID_W-1:0]  gen_grid = GRID_RST;

    int         items_sent   = 0;
    int         items_taken  = 0;
    int         random_cells = 0;
    int         fail_count   = 0;
    int         burst_left   = 0;
    int         idle_left    = 0;
    int         hold_left    = 0;
    int         mode_left    = 0;
    bit         hold_go      = 1'b0;
    bit         held_off     = 1'b0;
    t_flow_mode flow_mode    = FLOW_FREE;

    uniform_cross_detector #(
        .GRID_SIZE(STORE_SIDE),
        .MAX_ARM(ARM_LIMIT)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_pixel_value(i_pixel_value),
        .i_start_of_frame(i_start_of_frame),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_center_row(o_center_row),
        .o_center_col(o_center_col),
        .o_cross_value(o_cross_value),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int grid_in_use(input logic [GRID_W-1:0] gs);
        if (gs == 0) begin
            return 1;
        end
        if (gs > STORE_SIDE) begin
            return STORE_SIDE;
        end
        return gs;
    endfunction

    function automatic int arm_of(input logic [CROSS_W-1:0] cs);
        int a;
        a = cs / 2;
        return (a > ARM_LIMIT) ? ARM_LIMIT : a;
    endfunction

    // position the incoming cell takes
    function automatic void place_cell(input bit sof, input int g, inout int r, inout int c);
        if (sof) begin
            r = 0;
            c = 0;
        end else begin
            if (c >= g) begin
                c = 0;
                r = r + 1;
            end
            if (r >= g) begin
                r = 0;
            end
        end
    endfunction

    function automatic void step_on(input int g, inout int r, inout int c);
        c = c + 1;
        if (c >= g) begin
            c = 0;
            r = r + 1;
            if (r >= g) begin
                r = 0;
            end
        end
    endfunction

    task automatic take_cell(input logic [PIX_W-1:0] pix, input bit sof);
        int g;
        int arm;
        int r;
        int c;
        int cr;
        logic [PIX_W-1:0] lab;
        bit ok;
        g = grid_in_use(grid_cfg);
        arm = arm_of(span_cfg);
        r = pos_row;
        c = pos_col;
        place_cell(sof, g, r, c);
        cell_store[r*STORE_SIDE+c] = pix;
        if (r >= 2*arm && c >= arm && c + arm < g) begin
            cr = r - arm;
            lab = cell_store[cr*STORE_SIDE+c];
            ok = (lab != 0);
            for (int i = 1; i <= arm; i++) begin
                ok &= cell_store[(cr+i)*STORE_SIDE+c] == lab;
                ok &= cell_store[(cr-i)*STORE_SIDE+c] == lab;
                ok &= cell_store[cr*STORE_SIDE+c+i] == lab;
                ok &= cell_store[cr*STORE_SIDE+c-i] == lab;
            end
            if (ok) begin
                hits_due.push_back('{cr[COORD_W-1:0], c[COORD_W-1:0], lab});
            end
        end
        step_on(g, r, c);
        pos_row = r;
        pos_col = c;
    endtask

    // a cell whose check would read a never written entry starts a new frame instead
    task automatic queue_cell(input logic [PIX_W-1:0] pix, input bit sof);
        int g;
        int arm;
        int r;
        int c;
        bit risky;
        g = grid_in_use(gen_grid);
        arm = arm_of(gen_cross);
        r = gen_row;
        c = gen_col;
        place_cell(sof, g, r, c);
        risky = 1'b0;
        if (!sof && r >= 2*arm && c >= arm && c + arm < g) begin
            for (int i = 1; i <= 2*arm; i++) begin
                risky |= !gen_written[(r-i)*STORE_SIDE+c];
            end
            for (int i = -arm; i <= arm; i++) begin
                risky |= !gen_written[(r-arm)*STORE_SIDE+c+i];
            end
        end
        if (risky) begin
            sof = 1'b1;
            r = 0;
            c = 0;
        end
        gen_written[r*STORE_SIDE+c] = 1'b1;
        step_on(g, r, c);
        gen_row = r;
        gen_col = c;
        pending_cells.push_back('{pix, sof});
        items_sent++;
    endtask

    task automatic queue_frame(input int style_pick);
        int g;
        int arm;
        int style;
        int cells;
        int cr;
        int cc;
        int bad;
        logic [PIX_W-1:0] paint;
        logic [PIX_W-1:0] other;
        logic [PIX_W-1:0] img [STORE_SIDE*STORE_SIDE];
        g = grid_in_use(gen_grid);
        arm = arm_of(gen_cross);
        paint = PIX_W'($urandom_range(1, 255));
        other = PIX_W'($urandom_range(0, 255));
        style = (style_pick < 0) ? $urandom_range(0, 3) : style_pick;
        for (int k = 0; k < g*g; k++) begin
            case (style)
                0: img[k] = ($urandom_range(0, 9) == 0) ? other : paint;
                1: img[k] = '0;
                2: img[k] = ($urandom_range(0, 1) == 0) ? paint : other;
                default: img[k] = PIX_W'($urandom_range(0, 255));
            endcase
        end
        if (2*arm + 1 <= g) begin
            repeat ($urandom_range(1, 3)) begin
                cr = $urandom_range(arm, g - 1 - arm);
                cc = $urandom_range(arm, g - 1 - arm);
                for (int i = -arm; i <= arm; i++) begin
                    img[(cr+i)*g+cc] = paint;
                    img[cr*g+cc+i] = paint;
                end
                if ($urandom_range(0, 3) == 0) begin
                    bad = cr + $urandom_range(0, 2*arm) - arm;
                    img[bad*g+cc] = other;
                end
            end
        end
        cells = ($urandom_range(0, 4) == 0) ? $urandom_range(1, g*g) : g*g;
        for (int k = 0; k < cells; k++) begin
            queue_cell(img[k], (k == 0) ? ($urandom_range(0, 4) != 0)
                                        : ($urandom_range(0, 99) == 0));
        end
        random_cells += cells;
    endtask

    task automatic settle();
        while (items_taken != items_sent || hits_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        cfg_writes.push_back('{idx, data});
        if (idx == CFG_CROSS_SIZE) begin
            gen_cross = data[CROSS_W-1:0];
        end else begin
            gen_grid = data;
        end
        while (cfg_writes.size() != 0 || i_cfg_valid) begin
            @(negedge i_clk);
        end
    endtask

    // item and config driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            if (!i_valid || !o_stall) begin
                if (idle_left != 0) begin
                    idle_left--;
                    i_valid <= 1'b0;
                end else if (pending_cells.size() != 0) begin
                    next_cell = pending_cells.pop_front();
                    i_valid <= 1'b1;
                    i_pixel_value <= next_cell.pix;
                    i_start_of_frame <= next_cell.sof;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 30);
                        idle_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
            if (!i_cfg_valid || o_cfg_ready) begin
                if (cfg_writes.size() != 0) begin
                    next_write = cfg_writes.pop_front();
                    i_cfg_valid <= 1'b1;
                    i_cfg_index <= next_write.idx;
                    i_cfg_data <= next_write.data;
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (hold_go && !held_off) begin
            held_off = 1'b1;
            hold_left = HOLD_CYCLES;
            i_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                flow_mode = t_flow_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(10, 150);
            end else begin
                mode_left--;
            end
            case (flow_mode)
                FLOW_FREE: i_stall <= 1'b0;
                FLOW_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                FLOW_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
                default: i_stall <= ($urandom_range(0, 15) == 0) ? !i_stall : i_stall;
            endcase
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (t_cfg_idx'(i_cfg_index) == CFG_CROSS_SIZE) begin
                    span_cfg = i_cfg_data[CROSS_W-1:0];
                end else begin
                    grid_cfg = i_cfg_data;
                end
            end
            if (i_valid && !o_stall) begin
                items_taken++;
                take_cell(i_pixel_value, i_start_of_frame);
            end
            if (o_valid && !i_stall) begin
                if (hits_due.size() == 0) begin
                    $display("%0t: unexpected cross row %0d col %0d value %0d", $time,
                             o_center_row, o_center_col, o_cross_value);
                    fail_count++;
                end else begin
                    due_hit = hits_due.pop_front();
                    if (o_center_row !== due_hit.row) begin
                        $display("%0t: center_row expected %0d actual %0d", $time,
                                 due_hit.row, o_center_row);
                        fail_count++;
                    end
                    if (o_center_col !== due_hit.col) begin
                        $display("%0t: center_col expected %0d actual %0d", $time,
                                 due_hit.col, o_center_col);
                        fail_count++;
                    end
                    if (o_cross_value !== due_hit.label) begin
                        $display("%0t: cross_value expected %0d actual %0d", $time,
                                 due_hit.label, o_cross_value);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [CROSS_W-1:0] span_pick;
        logic [GRID_W-1:0]  grid_pick;
        int                 phase;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero arm on a one cell grid: every nonzero cell is a centre
        write_reg(CFG_CROSS_SIZE, 5'd1);
        write_reg(CFG_GRID_SIZE, 5'd0);
        queue_cell(8'd0, 1'b1);
        queue_cell(8'd255, 1'b0);
        queue_cell(8'd7, 1'b1);
        queue_cell(8'd128, 1'b0);
        queue_cell(8'd1, 1'b0);
        settle();

        // full plus on a 3x3 grid, then a broken bottom arm after the wrap
        write_reg(CFG_CROSS_SIZE, 5'd3);
        write_reg(CFG_GRID_SIZE, 5'd3);
        for (int k = 0; k < 9; k++) begin
            queue_cell((k % 2 == 1 || k == 4) ? 8'd255 : 8'd0, k == 0);
        end
        settle();
        write_reg(CFG_CROSS_SIZE, 5'd2);
        for (int k = 0; k < 9; k++) begin
            queue_cell((k == 7) ? 8'd254 : (k % 2 == 1 || k == 4) ? 8'd255 : 8'd0, 1'b0);
        end

        phase = 0;
        while (random_cells < RANDOM_TARGET) begin
            settle();
            case (phase)
                0: begin
                    span_pick = 4'd5;
                    grid_pick = 5'd7;
                end
                1: begin
                    span_pick = 4'd9;
                    grid_pick = 5'd9;
                end
                2: begin
                    span_pick = 4'd15;
                    grid_pick = 5'd31;
                end
                3: begin
                    span_pick = 4'd0;
                    grid_pick = 5'd5;
                end
                default: begin
                    span_pick = CROSS_W'(($urandom_range(0, 9) == 0) ? $urandom_range(8, 15)
                                                                     : $urandom_range(0, 7));
                    grid_pick = GRID_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                                    : $urandom_range(3, 8));
                end
            endcase
            if (phase < 4 || $urandom_range(0, 2) != 0) begin
                write_reg(CFG_CROSS_SIZE, {1'($urandom_range(0, 1)), span_pick});
            end
            if (phase < 4 || $urandom_range(0, 2) != 0) begin
                write_reg(CFG_GRID_SIZE, grid_pick);
            end
            if (phase == 0) begin
                queue_frame(0);
                hold_go = 1'b1;
            end else begin
                repeat ((phase < 4) ? 1 : $urandom_range(1, 2)) queue_frame(-1);
            end
            phase++;
        end

        settle();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
